[rtl/rtc_time_to_bcd_registers_unit_defines.svh]
// assertion macros shared by the rtc bcd encoder rtl
// no dependencies; each macro expects clk and rst in scope
`ifndef RTC_TIME_TO_BCD_REGISTERS_UNIT_DEFINES_SVH
`define RTC_TIME_TO_BCD_REGISTERS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define RTCBCD_ASSERT_HOLD(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define RTCBCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RTCBCD_ASSERT_HOLD(label, ante, cons, msg)

`define RTCBCD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/rtcbcd_pkg.sv]
// types, codes and small lookup functions for the rtc bcd encoder
// no dependencies
package rtcbcd_pkg;

  localparam int unsigned YEAR_BASE = 2000;

  typedef enum logic [2:0] {
    STATUS_OK     = 3'd0,
    STATUS_MONTH  = 3'd1,
    STATUS_DAY    = 3'd2,
    STATUS_HOUR   = 3'd3,
    STATUS_MINUTE = 3'd4,
    STATUS_SECOND = 3'd5,
    STATUS_YEAR   = 3'd6
  } status_t;

  typedef struct packed {
    logic [11:0] year_value;
    logic [3:0]  month_value;
    logic [4:0]  day_value;
    logic [4:0]  hour_value;
    logic [5:0]  minute_value;
    logic [5:0]  second_value;
    logic        mode_24h;
    logic        is_pm;
  } time_t;

  typedef struct packed {
    logic [7:0] seconds_byte;
    logic [7:0] minutes_byte;
    logic [7:0] hours_byte;
    logic [2:0] weekday_byte;
    logic [7:0] day_byte;
    logic [7:0] month_byte;
    logic [7:0] year_byte;
  } regs_t;

  // days in a common year, month 1..12
  function automatic logic [4:0] month_days(input logic [3:0] month);
    logic [4:0] days;
    unique case (month)
      4'd2:                      days = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
      default:                   days = 5'd31;
    endcase
    return days;
  endfunction

  // sakamoto month offsets
  function automatic logic [2:0] month_offset(input logic [3:0] month);
    logic [2:0] off;
    unique case (month)
      4'd2, 4'd6:   off = 3'd3;
      4'd3, 4'd11:  off = 3'd2;
      4'd4, 4'd7:   off = 3'd5;
      4'd8:         off = 3'd1;
      4'd9, 4'd12:  off = 3'd4;
      4'd10:        off = 3'd6;
      default:      off = 3'd0;
    endcase
    return off;
  endfunction

  // two-digit bcd of a value below 100, tens by reciprocal multiply
  function automatic logic [7:0] to_bcd(input logic [6:0] value);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(value) * 15'd205;
    tens = prod[14:11];
    ones = value - 7'({3'b000, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

[rtl/rtcbcd_check.sv]
// field validation for the rtc bcd encoder, first failing check wins
// depends on rtcbcd_pkg
module rtcbcd_check (
  input  rtcbcd_pkg::time_t   item,
  output rtcbcd_pkg::status_t status
);

  logic [24:0] cent_prod;
  logic [5:0]  century;
  logic [11:0] cent_rem;
  logic        leap;
  logic [4:0]  day_limit;
  logic        hour_bad;

  // year / 100 via reciprocal, exact over the 12-bit range
  assign cent_prod = 25'(item.year_value) * 25'd5243;
  assign century   = cent_prod[24:19];
  assign cent_rem  = item.year_value - 12'(12'(century) * 12'd100);
  assign leap      = ((item.year_value[1:0] == 2'b00) && (cent_rem != 12'd0))
                  || ((cent_rem == 12'd0) && (century[1:0] == 2'b00));

  assign day_limit = rtcbcd_pkg::month_days(item.month_value)
                   + {4'd0, (item.month_value == 4'd2) && leap};

  assign hour_bad = item.mode_24h ? (item.hour_value > 5'd23)
                  : ((item.hour_value == 5'd0) || (item.hour_value > 5'd12));

  always_comb begin
    priority if ((item.month_value == 4'd0) || (item.month_value > 4'd12)) begin
      status = rtcbcd_pkg::STATUS_MONTH;
    end else if ((item.day_value == 5'd0) || (item.day_value > day_limit)) begin
      status = rtcbcd_pkg::STATUS_DAY;
    end else if (hour_bad) begin
      status = rtcbcd_pkg::STATUS_HOUR;
    end else if (item.minute_value > 6'd59) begin
      status = rtcbcd_pkg::STATUS_MINUTE;
    end else if (item.second_value > 6'd59) begin
      status = rtcbcd_pkg::STATUS_SECOND;
    end else if ((item.year_value < 12'(rtcbcd_pkg::YEAR_BASE))
              || (item.year_value > 12'(rtcbcd_pkg::YEAR_BASE + 99))) begin
      status = rtcbcd_pkg::STATUS_YEAR;
    end else begin
      status = rtcbcd_pkg::STATUS_OK;
    end
  end

endmodule

[rtl/rtcbcd_encode.sv]
// bcd register bytes and weekday for a checked date and time
// depends on rtcbcd_pkg; all bytes forced to zero unless status is ok
module rtcbcd_encode (
  input  rtcbcd_pkg::time_t   item,
  input  rtcbcd_pkg::status_t status,
  output rtcbcd_pkg::regs_t   regs
);

  logic [11:0] year_off;
  logic [6:0]  yy;
  logic        early;
  logic [7:0]  yr_adj;
  logic [7:0]  yr_quarter;
  logic [7:0]  wd_sum;
  logic [14:0] wd_prod;
  logic [5:0]  wd_quot;
  logic [7:0]  wd_rem;
  logic [2:0]  weekday;
  logic [7:0]  hour_bcd;
  rtcbcd_pkg::regs_t full;

  assign year_off = item.year_value - 12'(rtcbcd_pkg::YEAR_BASE);
  assign yy       = year_off[6:0];

  // january and february count against the previous year; the year may
  // drop to -1 (1999), floor division by four keeps the sum right
  assign early      = item.month_value < 4'd3;
  assign yr_adj     = {1'b0, yy} - {7'd0, early};
  assign yr_quarter = {yr_adj[7], yr_adj[7], yr_adj[7:2]};

  // centuries fold to a constant that is 0 mod 7; +7 keeps the sum positive
  assign wd_sum = yr_adj + yr_quarter
                + {5'd0, rtcbcd_pkg::month_offset(item.month_value)}
                + {3'd0, item.day_value} + 8'd7;

  // mod 7 via reciprocal estimate and one correction step
  assign wd_prod = 15'(wd_sum) * 15'd73;
  assign wd_quot = wd_prod[14:9];
  assign wd_rem  = wd_sum - 8'({2'b00, wd_quot} * 8'd7);
  assign weekday = (wd_rem >= 8'd7) ? 3'(wd_rem - 8'd7) : wd_rem[2:0];

  assign hour_bcd = rtcbcd_pkg::to_bcd({2'b00, item.hour_value})
                  | {item.mode_24h, 1'b0, ~item.mode_24h & item.is_pm, 5'd0};

  always_comb begin
    full.seconds_byte = rtcbcd_pkg::to_bcd({1'b0, item.second_value});
    full.minutes_byte = rtcbcd_pkg::to_bcd({1'b0, item.minute_value});
    full.hours_byte   = hour_bcd;
    full.weekday_byte = weekday;
    full.day_byte     = rtcbcd_pkg::to_bcd({2'b00, item.day_value});
    full.month_byte   = rtcbcd_pkg::to_bcd({3'b000, item.month_value});
    full.year_byte    = rtcbcd_pkg::to_bcd(yy);
  end

  assign regs = (status == rtcbcd_pkg::STATUS_OK) ? full : '0;

endmodule

[rtl/rtc_time_to_bcd_registers_unit.sv]
// rtc date/time to bcd register encoder, top level; depends on rtcbcd_pkg,
// rtcbcd_check, rtcbcd_encode and the shared assertion macro header
// path: an accepted word is held in the input register, then in the result register
// throughput: one word per cycle while m_axis_tready is high, set by the input and result registers
// reset: synchronous active-high rst empties both register stages; payload keeps its value
// one result word per input word, in order
`include "rtc_time_to_bcd_registers_unit_defines.svh"

module rtc_time_to_bcd_registers_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // year_value[11:0], month_value[15:12], day_value[20:16], hour_value[25:21],
  // minute_value[31:26], second_value[37:32], zero fill[39:38]
  input  logic [39:0] s_axis_tdata,
  // mode_24h[0], is_pm[1]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // seconds_byte[7:0], minutes_byte[15:8], hours_byte[23:16], weekday_byte[26:24],
  // day_byte[34:27], month_byte[42:35], year_byte[50:43], zero fill[55:51]
  output logic [55:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser
);

  // input register stage
  logic                in_valid;
  rtcbcd_pkg::time_t   in_item;

  // result register stage
  logic                out_valid;
  rtcbcd_pkg::regs_t   out_regs;
  rtcbcd_pkg::status_t out_status;

  // combinational results from the input register
  rtcbcd_pkg::status_t status;
  rtcbcd_pkg::regs_t   regs;

  logic in_take;
  logic out_load;

  // result register frees when empty or when its word is taken
  assign out_load      = in_valid && (!out_valid || m_axis_tready);
  // input register takes a word when it is empty or when its word moves to the result register
  assign s_axis_tready = !in_valid || out_load;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (out_load) begin
      in_valid <= 1'b0;
    end
  end

  // unpack the stream word into named fields
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item.year_value   <= s_axis_tdata[11:0];
      in_item.month_value  <= s_axis_tdata[15:12];
      in_item.day_value    <= s_axis_tdata[20:16];
      in_item.hour_value   <= s_axis_tdata[25:21];
      in_item.minute_value <= s_axis_tdata[31:26];
      in_item.second_value <= s_axis_tdata[37:32];
      in_item.mode_24h     <= s_axis_tuser[0];
      in_item.is_pm        <= s_axis_tuser[1];
    end
  end

  // validation, then encoding gated by its status
  rtcbcd_check u_check (
    .item   (in_item),
    .status (status)
  );

  rtcbcd_encode u_encode (
    .item   (in_item),
    .status (status),
    .regs   (regs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_regs   <= regs;
      out_status <= status;
    end
  end

  // pack the result word, lowest field first
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {5'd0,
                          out_regs.year_byte,
                          out_regs.month_byte,
                          out_regs.day_byte,
                          out_regs.weekday_byte,
                          out_regs.hours_byte,
                          out_regs.minutes_byte,
                          out_regs.seconds_byte};

  // a failed check never carries register bytes
  `RTCBCD_ASSERT_HOLD(a_fail_zero, out_valid && (out_status != rtcbcd_pkg::STATUS_OK), out_regs == '0, "failed status with nonzero bytes")
  // weekday stays within sunday..saturday
  `RTCBCD_ASSERT_HOLD(a_weekday_range, out_valid, out_regs.weekday_byte != 3'd7, "weekday out of range")
  // an empty result register never blocks the input
  `RTCBCD_ASSERT_HOLD(a_ready_when_empty, !out_valid, s_axis_tready, "input stalled with empty result register")
  // a word moved forward shows up as a result next cycle
  `RTCBCD_ASSERT_NEXT(a_load_to_out, out_load, out_valid, "loaded result not valid")
  // a held input word is not dropped
  `RTCBCD_ASSERT_NEXT(a_in_hold, in_valid && !out_load, in_valid, "input word lost while stalled")

endmodule
